// ===== rtl/core/imh_pkg.sv =====
// Shared widths and command codes for the indexed min-heap unit.
package imh_pkg;

    localparam int CMD_W     = 2;
    localparam int NODE_ID_W = 13;
    localparam int KEY_W     = 32;
    localparam int COUNT_W   = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

endpackage

// ===== rtl/core/imh_req_if.sv =====
// Request channel: command word into the heap unit.
interface imh_req_if;

    logic                             valid;
    logic                             ready;
    logic [imh_pkg::CMD_W-1:0]        command;
    logic [imh_pkg::NODE_ID_W-1:0]    node_id;
    logic [imh_pkg::KEY_W-1:0]        key_value;

    modport source (
        output valid,
        output command,
        output node_id,
        output key_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  node_id,
        input  key_value,
        output ready
    );

endinterface

// ===== rtl/core/imh_rsp_if.sv =====
// Response channel: one result word per command.
interface imh_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [imh_pkg::NODE_ID_W-1:0]    popped_node;
    logic                             was_empty;
    logic [imh_pkg::COUNT_W-1:0]      entry_count;

    modport source (
        output valid,
        output popped_node,
        output was_empty,
        output entry_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  popped_node,
        input  was_empty,
        input  entry_count,
        output ready
    );

endinterface

// ===== rtl/core/imh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/indexed_min_heap_decrease_key_unit.sv =====
// Indexed binary min-heap with push / decrease-increase key / pop / clear.
//
//  channel | dir | word
//  --------+-----+---------------------------------------------
//  req     | in  | command, node_id, key_value
//  rsp     | out | popped_node, was_empty, entry_count
//
// One command at a time; req.ready is high only while the sequencer is idle.
// Clear and pop-on-empty go straight to the response; push reads the position RAM,
// then (for a queued node) the slot, and sifts up level by level; key raise and pop
// sift down level by level, all taking turns on the one slot read port and comparator.
// After reset a pass over all NUM_NODES entries zeroes the position RAM before req.ready.
// A result held on a stalled rsp blocks completion of the next command only.
module indexed_min_heap_decrease_key_unit #(
    parameter int NUM_NODES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    imh_req_if.sink     req,
    imh_rsp_if.source   rsp
);

    localparam int IDX_W = $clog2(NUM_NODES);
    localparam int CNT_W = $clog2(NUM_NODES + 1);
    localparam int CW    = IDX_W + 1;
    localparam int KEY_W = imh_pkg::KEY_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] node;
    } ent_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUSH_POS,
        S_PUSH_CHK,
        S_POP_TOP,
        S_POP_LAST,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_PLACE,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                clr_reg, clr_next;
    logic [IDX_W-1:0]                s_reg, s_next;
    ent_t                            ent_reg, ent_next;
    ent_t                            best_reg, best_next;
    logic                            best_left_reg, best_left_next;
    logic [IDX_W-1:0]                popped_reg, popped_next;
    logic                            empty_reg, empty_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [imh_pkg::NODE_ID_W-1:0]   rsp_node_reg, rsp_node_next;
    logic                            rsp_empty_reg, rsp_empty_next;
    logic [imh_pkg::COUNT_W-1:0]     rsp_count_reg, rsp_count_next;

    logic             slot_wr_en, slot_rd_en;
    logic [IDX_W-1:0] slot_wr_addr, slot_rd_addr;
    ent_t             slot_wr_data, slot_q;
    logic             pos_wr_en, pos_rd_en;
    logic [IDX_W-1:0] pos_wr_addr, pos_rd_addr, pos_wr_data, pos_q;

    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             key_lt, key_eq;
    logic [CW-1:0]    child_l, child_r, count_ext;
    logic [IDX_W-1:0] parent;
    logic             id_in_range;

    // slot RAM holds {key, node} so one read yields the key of a slot
    imh_ram #(
        .WIDTH (KEY_W + IDX_W),
        .DEPTH (NUM_NODES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_q)
    );

    imh_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_NODES)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_wr_en),
        .wr_addr (pos_wr_addr),
        .wr_data (pos_wr_data),
        .rd_en   (pos_rd_en),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_q)
    );

    // the one shared key comparator
    always_comb
    begin
        if (state_reg == S_DN_L || state_reg == S_DN_R)
        begin
            cmp_a = slot_q.key;
            cmp_b = (state_reg == S_DN_R) ? best_reg.key : ent_reg.key;
        end
        else
        begin
            cmp_a = ent_reg.key;
            cmp_b = slot_q.key;
        end
        key_lt = cmp_a < cmp_b;
        key_eq = cmp_a == cmp_b;
    end

    assign child_l     = {s_reg, 1'b1};
    assign child_r     = CW'(child_l + CW'(1));
    assign count_ext   = CW'(count_reg);
    assign parent      = (s_reg - IDX_W'(1)) >> 1;
    assign id_in_range = 32'(req.node_id) < NUM_NODES;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.popped_node = rsp_node_reg;
    assign rsp.was_empty   = rsp_empty_reg;
    assign rsp.entry_count = rsp_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        s_next         = s_reg;
        ent_next       = ent_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        popped_next    = popped_reg;
        empty_next     = empty_reg;
        rsp_node_next  = rsp_node_reg;
        rsp_empty_next = rsp_empty_reg;
        rsp_count_next = rsp_count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        slot_wr_en   = 1'b0;
        slot_wr_addr = '0;
        slot_wr_data = '0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = '0;
        pos_wr_en    = 1'b0;
        pos_wr_addr  = '0;
        pos_wr_data  = '0;
        pos_rd_en    = 1'b0;
        pos_rd_addr  = '0;

        unique case (state_reg)
            S_INIT:
            begin
                pos_wr_en   = 1'b1;
                pos_wr_addr = clr_reg;
                clr_next    = IDX_W'(clr_reg + IDX_W'(1));
                if (clr_reg == IDX_W'(NUM_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    popped_next = '0;
                    empty_next  = 1'b0;
                    unique case (imh_pkg::cmd_t'(req.command))
                        imh_pkg::CMD_PUSH:
                        begin
                            ent_next.key  = req.key_value;
                            ent_next.node = IDX_W'(req.node_id);
                            if (id_in_range)
                            begin
                                pos_rd_en   = 1'b1;
                                pos_rd_addr = IDX_W'(req.node_id);
                                state_next  = S_PUSH_POS;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        imh_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                empty_next = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                slot_rd_en = 1'b1;
                                state_next = S_POP_TOP;
                            end
                        end
                        imh_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // node is queued only if its recorded slot is live and holds it
            S_PUSH_POS:
            begin
                if (CW'(pos_q) < count_ext)
                begin
                    s_next       = pos_q;
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = pos_q;
                    state_next   = S_PUSH_CHK;
                end
                else
                begin
                    s_next     = IDX_W'(count_reg);
                    count_next = CNT_W'(count_reg + CNT_W'(1));
                    state_next = S_UP;
                end
            end

            S_PUSH_CHK:
            begin
                if (slot_q.node == ent_reg.node)
                begin
                    if (key_lt)
                    begin
                        state_next = S_UP;
                    end
                    else if (key_eq)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DN;
                    end
                end
                else
                begin
                    s_next     = IDX_W'(count_reg);
                    count_next = CNT_W'(count_reg + CNT_W'(1));
                    state_next = S_UP;
                end
            end

            S_POP_TOP:
            begin
                popped_next = slot_q.node;
                count_next  = CNT_W'(count_reg - CNT_W'(1));
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = IDX_W'(count_reg - CNT_W'(1));
                    state_next   = S_POP_LAST;
                end
            end

            S_POP_LAST:
            begin
                ent_next   = slot_q;
                s_next     = '0;
                state_next = S_DN;
            end

            // sift up with a hole: parents move down, entry written once at the end
            S_UP:
            begin
                if (s_reg == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = parent;
                    state_next   = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (key_lt)
                begin
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = s_reg;
                    slot_wr_data = slot_q;
                    pos_wr_en    = 1'b1;
                    pos_wr_addr  = slot_q.node;
                    pos_wr_data  = s_reg;
                    s_next       = parent;
                    state_next   = S_UP;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_DN:
            begin
                if (child_l >= count_ext)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = IDX_W'(child_l);
                    state_next   = S_DN_L;
                end
            end

            S_DN_L:
            begin
                best_next      = key_lt ? slot_q : ent_reg;
                best_left_next = key_lt;
                if (child_r < count_ext)
                begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = IDX_W'(child_r);
                    state_next   = S_DN_R;
                end
                else if (key_lt)
                begin
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = s_reg;
                    slot_wr_data = slot_q;
                    pos_wr_en    = 1'b1;
                    pos_wr_addr  = slot_q.node;
                    pos_wr_data  = s_reg;
                    s_next       = IDX_W'(child_l);
                    state_next   = S_DN;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            // right child wins only if strictly below the best so far
            S_DN_R:
            begin
                if (key_lt)
                begin
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = s_reg;
                    slot_wr_data = slot_q;
                    pos_wr_en    = 1'b1;
                    pos_wr_addr  = slot_q.node;
                    pos_wr_data  = s_reg;
                    s_next       = IDX_W'(child_r);
                    state_next   = S_DN;
                end
                else if (best_left_reg)
                begin
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = s_reg;
                    slot_wr_data = best_reg;
                    pos_wr_en    = 1'b1;
                    pos_wr_addr  = best_reg.node;
                    pos_wr_data  = s_reg;
                    s_next       = IDX_W'(child_l);
                    state_next   = S_DN;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = s_reg;
                slot_wr_data = ent_reg;
                pos_wr_en    = 1'b1;
                pos_wr_addr  = ent_reg.node;
                pos_wr_data  = s_reg;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_node_next  = imh_pkg::NODE_ID_W'(popped_reg);
                    rsp_empty_next = empty_reg;
                    rsp_count_next = imh_pkg::COUNT_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= '0;
            clr_reg       <= '0;
            s_reg         <= '0;
            ent_reg       <= '0;
            best_reg      <= '0;
            best_left_reg <= 1'b0;
            popped_reg    <= '0;
            empty_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_node_reg  <= '0;
            rsp_empty_reg <= 1'b0;
            rsp_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            s_reg         <= s_next;
            ent_reg       <= ent_next;
            best_reg      <= best_next;
            best_left_reg <= best_left_next;
            popped_reg    <= popped_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_node_reg  <= rsp_node_next;
            rsp_empty_reg <= rsp_empty_next;
            rsp_count_reg <= rsp_count_next;
        end
    end

endmodule
